[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the block checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FBB_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define FBB_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/fbb_pkg.sv]
// ----------------------------------------------------------------------------
// fbb_pkg
// widths, constants and control types of the fractional box blur line
// ----------------------------------------------------------------------------
package fbb_pkg;

  localparam int unsigned MAX_RADIUS_DEF = 510;

  localparam int unsigned PIXEL_W  = 8;
  localparam int unsigned RADIUS_W = 9;
  localparam int unsigned FRAC_W   = 4;
  localparam int unsigned SUM_W    = 18;
  localparam int unsigned FILL_W   = 11;
  localparam int unsigned SPAN_W   = RADIUS_W + 1;
  localparam int unsigned RECIP_W  = 17;
  localparam int unsigned DIV_W    = 15;
  localparam int unsigned NUM_W    = 21;
  localparam int unsigned ACC_W    = 22;
  localparam int unsigned PROD_W   = ACC_W + RECIP_W;
  localparam int unsigned Q_SHIFT  = 20;
  localparam int unsigned WEIGHT_SHIFT = 4;

  localparam int unsigned ONE_Q20 = 1048576;

  localparam int unsigned RESET_RADIUS = 10;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRACTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND    = 2'd2;

  typedef struct packed {
    logic accept;
    logic mem_rd;
    logic acc_step;
    logic mul_step;
    logic out_load;
    logic cfg_we;
    logic div_start;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
    logic div_done;
  } dp_status_t;

endpackage

[rtl/core/fbb_recip.sv]
// ----------------------------------------------------------------------------
// fbb_recip
// restoring divider, one quotient bit per cycle, for the reciprocal
// ----------------------------------------------------------------------------
module fbb_recip (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fbb_pkg::NUM_W-1:0]   numer_i,
  input  logic [fbb_pkg::DIV_W-1:0]   denom_i,
  output logic                        done_o,
  output logic [fbb_pkg::RECIP_W-1:0] quot_o
);
  import fbb_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] den_q, den_d;
  logic [DIV_W:0]   rem_sh;
  logic             qbit;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    rem_sh = {rem_q, num_q[NUM_W-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      num_d  = numer_i;
      rem_d  = '0;
      den_d  = denom_i;
    end else if (busy_q) begin
      // shift in one numerator bit, subtract when it fits
      rem_d = qbit ? DIV_W'(rem_sh - {1'b0, den_q}) : DIV_W'(rem_sh);
      num_d = {num_q[NUM_W-2:0], qbit};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q[RECIP_W-1:0];

endmodule

[rtl/core/fbb_ctrl.sv]
// ----------------------------------------------------------------------------
// fbb_ctrl
// sequencer for sample processing and reciprocal recompute
// ----------------------------------------------------------------------------
module fbb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fbb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  fbb_pkg::dp_status_t           status_i,
  output fbb_pkg::dp_cmd_t              cmd_o
);
  import fbb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DSTART = 7'b0000010,
    S_DWAIT  = 7'b0000100,
    S_RD     = 7'b0001000,
    S_ACC    = 7'b0010000,
    S_MUL    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   idx_ok;

  assign idx_ok = (cfg_index_i == REG_RADIUS) || (cfg_index_i == REG_FRACTION) ||
                  (cfg_index_i == REG_ROUND);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) begin
          cmd_o.cfg_we = 1'b1;
          if (idx_ok) begin
            state_d = S_DSTART;
          end
        end else if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_RD;
        end
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (status_i.div_done) begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_step = 1'b1;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (!status_i.emit) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration wins when both channels present a beat in idle
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;

endmodule

[rtl/core/fbb_dp.sv]
// ----------------------------------------------------------------------------
// fbb_dp
// sample ring, running sum, weighted multiply and output register
// ----------------------------------------------------------------------------
module fbb_dp #(
  parameter int unsigned MAX_RADIUS = fbb_pkg::MAX_RADIUS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fbb_pkg::dp_cmd_t               cmd_i,
  output fbb_pkg::dp_status_t            status_o,
  input  logic [fbb_pkg::PIXEL_W-1:0]    pixel_in_i,
  input  logic                           line_end_i,
  input  logic [fbb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fbb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [fbb_pkg::PIXEL_W-1:0]    pixel_out_o,
  output logic                           last_out_o
);
  import fbb_pkg::*;

  localparam int unsigned Depth = 2 * MAX_RADIUS + 4;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned OFS_W = ((AW > FILL_W) ? AW : FILL_W) + 1;

  // reset reciprocal follows the clipped reset radius
  localparam int unsigned ResetRadius =
    (RESET_RADIUS > MAX_RADIUS) ? MAX_RADIUS : RESET_RADIUS;
  localparam logic [RECIP_W-1:0] RecipReset =
    RECIP_W'(ONE_Q20 / ((2 * ResetRadius + 1) * 16));

  // configuration
  logic [RADIUS_W-1:0] radius_q;
  logic [FRAC_W-1:0]   frac_q;
  logic                round_q;
  logic [RECIP_W-1:0]  recip_q;

  // line state
  logic [SUM_W-1:0]  sum_q;
  logic [FILL_W-1:0] fill_q;
  logic [AW-1:0]     wp_q;

  // per-sample payload
  logic [PIXEL_W-1:0] px_q;
  logic               last_q;
  logic [PIXEL_W-1:0] far_q, near_q;
  logic [ACC_W-1:0]   acc_q;
  logic [PROD_W-1:0]  prod_q;
  logic               emit_q, emit_last_q;

  logic               out_valid_q;
  logic [PIXEL_W-1:0] out_pixel_q;
  logic               out_last_q;

  logic [PIXEL_W-1:0] mem [Depth];

  logic [RADIUS_W-1:0] eff_r;
  logic [SPAN_W-1:0]   span;
  logic [FILL_W-1:0]   span_f, span1_f;
  logic [OFS_W-1:0]    far_diff, near_diff;
  logic [AW-1:0]       far_addr, near_addr;
  logic [DIV_W-1:0]    denom;
  logic [NUM_W-1:0]    numer;
  logic                div_done;
  logic [RECIP_W-1:0]  div_quot;
  logic [PIXEL_W:0]    edges;
  logic [ACC_W-1:0]    acc_d;
  logic [PROD_W-Q_SHIFT-1:0] y_full;
  logic [PIXEL_W-1:0]  y_sat;
  logic                out_free;

  assign eff_r   = (32'(radius_q) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : radius_q;
  assign span    = {eff_r, 1'b1};
  assign span_f  = FILL_W'(span);
  assign span1_f = FILL_W'(span) + FILL_W'(1);

  // ring addresses of the two samples that leave the window
  assign far_diff  = OFS_W'(wp_q) - OFS_W'(span1_f);
  assign near_diff = OFS_W'(wp_q) - OFS_W'(span_f);
  assign far_addr  = far_diff[OFS_W-1] ? AW'(far_diff + OFS_W'(Depth)) : AW'(far_diff);
  assign near_addr = near_diff[OFS_W-1] ? AW'(near_diff + OFS_W'(Depth)) : AW'(near_diff);

  // divisor (2r+1)*16 + 2*frac and rounded numerator
  assign denom = DIV_W'({span, {WEIGHT_SHIFT{1'b0}}}) + DIV_W'({frac_q, 1'b0});
  assign numer = NUM_W'(ONE_Q20) + (round_q ? (NUM_W'(denom) + NUM_W'(1)) : '0);

  fbb_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .numer_i (numer),
    .denom_i (denom),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign edges = {1'b0, far_q} + {1'b0, px_q};
  assign acc_d = ACC_W'(edges) * ACC_W'(frac_q) + ACC_W'({sum_q, {WEIGHT_SHIFT{1'b0}}});

  assign y_full = prod_q[PROD_W-1:Q_SHIFT];
  assign y_sat  = (|y_full[PROD_W-Q_SHIFT-1:PIXEL_W]) ? {PIXEL_W{1'b1}}
                                                       : y_full[PIXEL_W-1:0];

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= RADIUS_W'(RESET_RADIUS);
      frac_q      <= '0;
      round_q     <= 1'b0;
      recip_q     <= RecipReset;
      sum_q       <= '0;
      fill_q      <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_we) begin
        case (cfg_index_i)
          REG_RADIUS: begin
            radius_q <= cfg_data_i[RADIUS_W-1:0];
            sum_q    <= '0;
            fill_q   <= '0;
          end
          REG_FRACTION: begin
            frac_q <= cfg_data_i[FRAC_W-1:0];
            sum_q  <= '0;
            fill_q <= '0;
          end
          REG_ROUND: begin
            round_q <= cfg_data_i[0];
            sum_q   <= '0;
            fill_q  <= '0;
          end
          default: begin
          end
        endcase
      end
      if (div_done) begin
        recip_q <= div_quot;
      end
      if (cmd_i.acc_step) begin
        if (last_q) begin
          sum_q  <= '0;
          fill_q <= '0;
        end else begin
          sum_q <= (fill_q >= span_f) ? (sum_q + SUM_W'(px_q) - SUM_W'(near_q))
                                      : (sum_q + SUM_W'(px_q));
          if (fill_q < span1_f) begin
            fill_q <= fill_q + FILL_W'(1);
          end
        end
        wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      px_q   <= pixel_in_i;
      last_q <= line_end_i;
    end
    if (cmd_i.mem_rd) begin
      far_q  <= mem[far_addr];
      near_q <= mem[near_addr];
    end
    if (cmd_i.acc_step) begin
      mem[wp_q]   <= px_q;
      acc_q       <= acc_d;
      emit_q      <= (fill_q >= span1_f);
      emit_last_q <= last_q;
    end
    if (cmd_i.mul_step) begin
      prod_q <= PROD_W'(acc_q) * PROD_W'(recip_q);
    end
    if (cmd_i.out_load) begin
      out_pixel_q <= y_sat;
      out_last_q  <= emit_last_q;
    end
  end

  assign status_o.emit     = emit_q;
  assign status_o.out_free = out_free;
  assign status_o.div_done = div_done;

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pixel_q;
  assign last_out_o  = out_last_q;

endmodule

[rtl/core/fractional_box_blur_line.sv]
// ----------------------------------------------------------------------------
// fractional_box_blur_line
// one-line box blur with fractional edge weights and running-sum window
// ----------------------------------------------------------------------------
// Each accepted sample passes through these steps in order: the accept beat,
// a two-port read of the sample ring, the running-sum update with the edge
// weighting, one 22x17 multiply, and the load of the output register, which
// waits while the held result is stalled; a new sample is taken only once the
// last one is through, and the output register holds a finished result while
// the next sample is already being accepted. The first 2r+2 samples of a line
// only fill the window and give no result; after that each sample gives one
// result, saturated to 255, with last_out set on the result caused by the
// line_end sample. A write to any of the three configuration registers
// restarts the current line and recomputes the reciprocal with a bit-serial
// divider before samples are accepted again. A write to an unused index is
// accepted and ignored. The sample ring has 2*MAX_RADIUS+4 entries and needs
// no clearing after reset.
module fractional_box_blur_line #(
  parameter int unsigned MAX_RADIUS = fbb_pkg::MAX_RADIUS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [fbb_pkg::PIXEL_W-1:0]    pixel_in_i,
  input  logic                           line_end_i,
  // result output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fbb_pkg::PIXEL_W-1:0]    pixel_out_o,
  output logic                           last_out_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fbb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fbb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fbb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller: sequences each sample and the reciprocal recompute
  fbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: ring, sums, multiply, divider and output register
  fbb_dp #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .pixel_in_i  (pixel_in_i),
    .line_end_i  (line_end_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .pixel_out_o (pixel_out_o),
    .last_out_o  (last_out_o)
  );

endmodule

[rtl/core/fbb_checker.sv]
// ----------------------------------------------------------------------------
// fbb_checker
// port-level checks of the fractional box blur line
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [fbb_pkg::PIXEL_W-1:0]    pixel_out_o,
  input logic                           last_out_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [fbb_pkg::CFG_IDX_W-1:0]  cfg_index_i
);
  import fbb_pkg::*;

  logic in_beat, cfg_beat, cfg_beat_used;

  assign in_beat       = in_valid_i && !in_stall_o;
  assign cfg_beat      = cfg_valid_i && cfg_ready_o;
  assign cfg_beat_used = cfg_beat && ((cfg_index_i == REG_RADIUS) ||
                         (cfg_index_i == REG_FRACTION) || (cfg_index_i == REG_ROUND));

  // a held result keeps its payload
  `FBB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                  out_valid_o && $stable(pixel_out_o) && $stable(last_out_o))

  // one sample at a time: no beat right after an accepted sample
  `FBB_ASSERT_NXT(a_in_one_at_a_time, clk_i, rst_ni, in_beat, in_stall_o)

  // reciprocal recompute keeps both channels closed
  `FBB_ASSERT_NXT(a_cfg_recompute, clk_i, rst_ni, cfg_beat_used,
                  in_stall_o && !cfg_ready_o)

  // config port closed means the sample port is closed too
  `FBB_ASSERT_IMP(a_busy_stall, clk_i, rst_ni, !cfg_ready_o, in_stall_o)

endmodule

bind fractional_box_blur_line fbb_checker u_fbb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pixel_out_o (pixel_out_o),
  .last_out_o  (last_out_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i)
);
